[hdl/length_prefixed_adler_frame_checker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame checker
// Concurrent property wrappers that report by $error.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_ADLER_FRAME_CHECKER_MACROS_SVH
`define LENGTH_PREFIXED_ADLER_FRAME_CHECKER_MACROS_SVH

// same-cycle implication
`define LPAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame checker assertion failed");

// next-cycle implication
`define LPAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame checker assertion failed");

`endif

[hdl/lpaf_pkg.sv]
// ----------------------------------------------------------------------------
// lpaf_pkg
// Shared constants, codes and types of the length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lpaf_pkg;

	localparam int HEADER_BYTES  = 4;
	localparam int CHECK_BYTES   = 4;
	localparam int MAX_TAG_BYTES = 8;

	localparam int LEN_W      = 27;
	localparam int TAG_LEN_W  = 4;
	localparam int TAG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic [16:0] ADLER_MOD = 17'd65521;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADLEN = 2'd1,
		ST_BADSUM = 2'd2,
		ST_BADTAG = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_LENGTH = 2'd0,
		CFG_MAX_LENGTH = 2'd1,
		CFG_TAG_LENGTH = 2'd2,
		CFG_TAG_BYTES  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

endpackage

[hdl/length_prefixed_adler_frame_checker.sv]
// ----------------------------------------------------------------------------
// length_prefixed_adler_frame_checker: length-prefixed frame check, Adler-32
// An accepted input beat is registered into the input stage, then its result into the output register.
// Throughput: 1 beat per cycle while the output is not stalled; one pass of the Adler update per beat.
// Reset: arst_n clears frame state to header phase and registers to defaults.
// ----------------------------------------------------------------------------
module length_prefixed_adler_frame_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpaf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpaf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lpaf_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	input  logic                             s_axis_tuser,  // [0] cmd
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] payload_byte, [9:8] status, [36:10] frame_length, [39:37] zero
	output logic [lpaf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tuser   // [0] kind
);
	import lpaf_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_BODY   = 3'b010,
		PH_HALT   = 3'b100
	} phase_t;

	logic [LEN_W-1:0]     min_length_q;
	logic [LEN_W-1:0]     max_length_q;
	logic [TAG_LEN_W-1:0] tag_length_q;
	logic [TAG_W-1:0]     tag_bytes_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  header_count_q, header_count_d;
	logic [31:0] length_held_q, length_held_d;
	logic [LEN_W-1:0] body_index_q, body_index_d;
	logic [15:0] sum_low_q, sum_low_d;
	logic [15:0] sum_high_q, sum_high_d;
	logic        tag_matched_q, tag_matched_d;
	logic [31:0] received_sum_q, received_sum_d;

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;

	logic        advance;
	logic        fire;

	logic        res_valid;
	logic        res_kind;
	logic [7:0]  res_byte;
	status_t     res_status;
	logic [LEN_W-1:0] res_length;

	logic [TAG_LEN_W-1:0] tl;
	logic [31:0] hdr_length;
	logic [31:0] data_end;
	logic [LEN_W:0] idx_inc;
	logic [16:0] low_sum;
	logic [15:0] low_mod;
	logic [16:0] high_sum;
	logic [15:0] high_mod;
	logic [7:0]  want;
	logic [31:0] calc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= LEN_W'(4);
			max_length_q <= LEN_W'(67108864);
			tag_length_q <= '0;
			tag_bytes_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_LENGTH: min_length_q <= cfg_data[LEN_W-1:0];
				CFG_MAX_LENGTH: max_length_q <= cfg_data[LEN_W-1:0];
				CFG_TAG_LENGTH: tag_length_q <= cfg_data[TAG_LEN_W-1:0];
				CFG_TAG_BYTES:  tag_bytes_q  <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
		end
	end

	assign tl = (tag_length_q > TAG_LEN_W'(MAX_TAG_BYTES)) ?
		TAG_LEN_W'(MAX_TAG_BYTES) : tag_length_q;
	assign hdr_length = {length_held_q[23:0], byte_s1};
	assign data_end   = length_held_q - 32'(CHECK_BYTES);
	assign idx_inc    = {1'b0, body_index_q} + (LEN_W+1)'(1);

	assign low_sum  = {1'b0, sum_low_q} + {9'b0, byte_s1};
	assign low_mod  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
	assign high_sum = {1'b0, sum_high_q} + {1'b0, low_mod};
	assign high_mod = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
	assign want     = tag_bytes_q[{body_index_q[2:0], 3'b000} +: 8];

	always_comb begin
		phase_d        = phase_q;
		header_count_d = header_count_q;
		length_held_d  = length_held_q;
		body_index_d   = body_index_q;
		sum_low_d      = sum_low_q;
		sum_high_d     = sum_high_q;
		tag_matched_d  = tag_matched_q;
		received_sum_d = received_sum_q;
		res_valid      = 1'b0;
		res_kind       = KIND_PAYLOAD;
		res_byte       = '0;
		res_status     = ST_OK;
		res_length     = '0;
		calc           = '0;
		if (cmd_s1) begin
			phase_d        = PH_HEADER;
			header_count_d = '0;
			length_held_d  = '0;
			body_index_d   = '0;
			sum_low_d      = 16'd1;
			sum_high_d     = '0;
			tag_matched_d  = 1'b1;
			received_sum_d = '0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					length_held_d  = hdr_length;
					header_count_d = header_count_q + 2'd1;
					if (header_count_q == 2'(HEADER_BYTES - 1)) begin
						header_count_d = '0;
						if (hdr_length > {5'b0, max_length_q} ||
						    hdr_length < {5'b0, min_length_q} ||
						    hdr_length < {28'b0, tl} + 32'(CHECK_BYTES)) begin
							phase_d    = PH_HALT;
							res_valid  = 1'b1;
							res_kind   = KIND_VERDICT;
							res_status = ST_BADLEN;
							res_length = (hdr_length[31:LEN_W] != '0) ?
								'1 : hdr_length[LEN_W-1:0];
						end else begin
							phase_d        = PH_BODY;
							body_index_d   = '0;
							sum_low_d      = 16'd1;
							sum_high_d     = '0;
							tag_matched_d  = 1'b1;
							received_sum_d = '0;
						end
					end
				end
				PH_BODY: begin
					if ({5'b0, body_index_q} < data_end) begin
						sum_low_d  = low_mod;
						sum_high_d = high_mod;
						if (body_index_q < {{(LEN_W-TAG_LEN_W){1'b0}}, tl}) begin
							if (want != byte_s1) begin
								tag_matched_d = 1'b0;
							end
						end else begin
							res_valid = 1'b1;
							res_byte  = byte_s1;
						end
					end else begin
						received_sum_d = {received_sum_q[23:0], byte_s1};
					end
					body_index_d = idx_inc[LEN_W-1:0];
					if ({4'b0, idx_inc} >= length_held_q) begin
						calc       = {sum_high_d, sum_low_d};
						res_valid  = 1'b1;
						res_kind   = KIND_VERDICT;
						res_byte   = '0;
						res_length = length_held_q[LEN_W-1:0];
						if (calc != received_sum_d) begin
							res_status = ST_BADSUM;
						end else if (!tag_matched_d) begin
							res_status = ST_BADTAG;
						end else begin
							res_status = ST_OK;
						end
						phase_d        = (res_status == ST_OK) ? PH_HEADER : PH_HALT;
						header_count_d = '0;
						length_held_d  = '0;
						body_index_d   = '0;
						sum_low_d      = 16'd1;
						sum_high_d     = '0;
						tag_matched_d  = 1'b1;
						received_sum_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_count_q <= '0;
			length_held_q  <= '0;
			body_index_q   <= '0;
			sum_low_q      <= 16'd1;
			sum_high_q     <= '0;
			tag_matched_q  <= 1'b1;
			received_sum_q <= '0;
		end else if (fire) begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			length_held_q  <= length_held_d;
			body_index_q   <= body_index_d;
			sum_low_q      <= sum_low_d;
			sum_high_q     <= sum_high_d;
			tag_matched_q  <= tag_matched_d;
			received_sum_q <= received_sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			m_axis_tuser <= res_kind;
			m_axis_tdata <= {3'b000, res_length, res_status, res_byte};
		end
	end

endmodule

[hdl/lpaf_checker.sv]
// ----------------------------------------------------------------------------
// lpaf_checker
// Port-level checks on the result stream of the frame checker.
// ----------------------------------------------------------------------------
`include "length_prefixed_adler_frame_checker_macros.svh"

module lpaf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lpaf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tuser
);
	import lpaf_pkg::*;

	// hold a stalled result beat
	`LPAF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`LPAF_ASSERT_NOW(a_payload_clean, clk, arst_n, m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD), m_axis_tdata[OUT_DATA_W-1:8] == '0)
	`LPAF_ASSERT_NOW(a_verdict_clean, clk, arst_n, m_axis_tvalid && (m_axis_tuser == KIND_VERDICT), (m_axis_tdata[7:0] == '0) && (m_axis_tdata[OUT_DATA_W-1:LEN_W+10] == '0))
	// a good frame always carries at least its checksum
	`LPAF_ASSERT_NOW(a_ok_length, clk, arst_n, m_axis_tvalid && (m_axis_tuser == KIND_VERDICT) && (m_axis_tdata[9:8] == ST_OK), m_axis_tdata[LEN_W+9:10] >= LEN_W'(CHECK_BYTES))

endmodule

bind length_prefixed_adler_frame_checker lpaf_checker u_lpaf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[sim/lpaf_tb_pkg.sv]
// ----------------------------------------------------------------------------
// lpaf_tb_pkg
// Stream command codes shared by the frame checker testbench and its monitor.
// ----------------------------------------------------------------------------
package lpaf_tb_pkg;

	typedef enum logic {
		CMD_DATA   = 1'b0,
		CMD_RESYNC = 1'b1
	} rx_cmd_t;

endpackage

[sim/lpaf_frame_monitor.sv]
// ----------------------------------------------------------------------------
// lpaf_frame_monitor
// Watches the register, input and output channels of the frame checker. Keeps
// its own copy of the registers and of the frame state, predicts the forwarded
// payload beats and frame verdicts for every accepted input beat, and compares
// each accepted output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lpaf_frame_monitor
	import lpaf_pkg::*;
	import lpaf_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic                  s_axis_tuser,   // [0] cmd
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] payload_byte, [9:8] status, [36:10] frame_length, [39:37] zero
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tuser,   // [0] kind
	output int                    mismatches,
	output int                    pending
);

	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_HALT   = 2'd2
	} frame_phase_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       payload_byte;
		status_t          status;
		logic [LEN_W-1:0] frame_length;
	} out_beat_t;

	out_beat_t expected_beats[$];
	out_beat_t want_beat;
	int        fault_count;

	logic [LEN_W-1:0]     min_len;
	logic [LEN_W-1:0]     max_len;
	logic [TAG_LEN_W-1:0] tag_len;
	logic [TAG_W-1:0]     tag_val;

	frame_phase_t     phase_q;
	int unsigned      hdr_cnt;
	logic [31:0]      len_hold;
	logic [LEN_W-1:0] body_idx;
	logic [15:0]      sum_lo;
	logic [15:0]      sum_hi;
	logic             tag_ok;
	logic [31:0]      rx_sum;

	function automatic out_beat_t make_beat(input kind_t k, input logic [7:0] b,
			input status_t st, input logic [LEN_W-1:0] len);
		out_beat_t r;
		r.kind         = k;
		r.payload_byte = b;
		r.status       = st;
		r.frame_length = len;
		return r;
	endfunction

	task automatic clear_frame();
		phase_q  = PH_HEADER;
		hdr_cnt  = 0;
		len_hold = '0;
		body_idx = '0;
		sum_lo   = 16'd1;
		sum_hi   = '0;
		tag_ok   = 1'b1;
		rx_sum   = '0;
	endtask

	task automatic push_verdict(input status_t st, input logic [31:0] len);
		expected_beats.push_back(make_beat(KIND_VERDICT, 8'h00, st,
			(len > 32'(LEN_SAT)) ? LEN_SAT : len[LEN_W-1:0]));
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (fault_count < 200)
			$display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, field, got, want);
		fault_count++;
	endtask

	task automatic predict_rx_beat(input rx_cmd_t cmd, input logic [7:0] b);
		int unsigned tl;
		int unsigned idx;
		int unsigned lo;
		int unsigned hi;
		status_t     st;
		logic [31:0] flen;
		tl = (tag_len > MAX_TAG_BYTES) ? MAX_TAG_BYTES : tag_len;
		if (cmd == CMD_RESYNC) begin
			clear_frame();
		end else if (phase_q == PH_HEADER) begin
			len_hold = {len_hold[23:0], b};
			hdr_cnt++;
			if (hdr_cnt == HEADER_BYTES) begin
				hdr_cnt = 0;
				if (len_hold > max_len || len_hold < min_len ||
						len_hold < tl + CHECK_BYTES) begin
					phase_q = PH_HALT;
					push_verdict(ST_BADLEN, len_hold);
				end else begin
					phase_q  = PH_BODY;
					body_idx = '0;
					sum_lo   = 16'd1;
					sum_hi   = '0;
					tag_ok   = 1'b1;
					rx_sum   = '0;
				end
			end
		end else if (phase_q == PH_BODY) begin
			idx = body_idx;
			if (idx < len_hold - CHECK_BYTES) begin
				lo = (sum_lo + b) % ADLER_MOD;
				hi = (sum_hi + lo) % ADLER_MOD;
				sum_lo = lo[15:0];
				sum_hi = hi[15:0];
				if (idx < tl) begin
					if (tag_val[8*idx +: 8] != b)
						tag_ok = 1'b0;
				end else begin
					expected_beats.push_back(make_beat(KIND_PAYLOAD, b, ST_OK, '0));
				end
			end else begin
				rx_sum = {rx_sum[23:0], b};
			end
			body_idx = idx + 1;
			if (idx + 1 >= len_hold) begin
				if ({sum_hi, sum_lo} != rx_sum)
					st = ST_BADSUM;
				else if (!tag_ok)
					st = ST_BADTAG;
				else
					st = ST_OK;
				flen = len_hold;
				clear_frame();
				if (st != ST_OK)
					phase_q = PH_HALT;
				push_verdict(st, flen);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len = LEN_W'(4);
			max_len = LEN_W'(67108864);
			tag_len = '0;
			tag_val = '0;
			clear_frame();
			expected_beats.delete();
			fault_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MIN_LENGTH: min_len = cfg_data[LEN_W-1:0];
					CFG_MAX_LENGTH: max_len = cfg_data[LEN_W-1:0];
					CFG_TAG_LENGTH: tag_len = cfg_data[TAG_LEN_W-1:0];
					CFG_TAG_BYTES:  tag_val = cfg_data[TAG_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_rx_beat(rx_cmd_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", {m_axis_tuser, m_axis_tdata}, '0);
				end else begin
					want_beat = expected_beats.pop_front();
					if (m_axis_tuser !== want_beat.kind)
						report_mismatch("kind", m_axis_tuser, want_beat.kind);
					if (m_axis_tdata[7:0] !== want_beat.payload_byte)
						report_mismatch("payload_byte", m_axis_tdata[7:0],
							want_beat.payload_byte);
					if (m_axis_tdata[9:8] !== want_beat.status)
						report_mismatch("status", m_axis_tdata[9:8], want_beat.status);
					if (m_axis_tdata[36:10] !== want_beat.frame_length)
						report_mismatch("frame_length", m_axis_tdata[36:10],
							want_beat.frame_length);
					if (m_axis_tdata[39:37] !== 3'b000)
						report_mismatch("padding", m_axis_tdata[39:37], '0);
				end
			end
			mismatches <= fault_count;
			pending    <= expected_beats.size();
		end
	end

endmodule

[sim/tb_length_prefixed_adler_frame_checker.sv]
// ----------------------------------------------------------------------------
// tb_length_prefixed_adler_frame_checker
// Drives framed byte streams into the frame checker: well-formed frames with
// random payloads, checksum and tag faults, bad lengths, cut frames and noise,
// each error followed by ignored bytes and a resync. Runs several register
// settings, random stalls on both channels, and lets the monitor judge.
// ----------------------------------------------------------------------------
module tb_length_prefixed_adler_frame_checker;
	import lpaf_pkg::*;
	import lpaf_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_PCT    = 21;
	localparam int PAYLOAD_MAX  = 24;
	localparam int PHASE_BEATS  = 100;
	localparam logic [63:0] LEN_TOP = 64'd67108864;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	int errors;
	int pending;
	int cycles = 0;
	int beats_sent = 0;
	bit stall_on = 1'b1;

	logic [LEN_W-1:0]     cur_min;
	logic [LEN_W-1:0]     cur_max;
	logic [TAG_LEN_W-1:0] cur_tag_len;
	logic [TAG_W-1:0]     cur_tag;

	always #6 clk = ~clk;

	length_prefixed_adler_frame_checker dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	lpaf_frame_monitor frame_monitor (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.mismatches(errors), .pending(pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= !(stall_on && $urandom_range(0, 99) < STALL_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int eff_tag_len();
		return (cur_tag_len > MAX_TAG_BYTES) ? MAX_TAG_BYTES : int'(cur_tag_len);
	endfunction

	task automatic send_beat(input rx_cmd_t cmd, input logic [7:0] b);
		if (stall_on && $urandom_range(0, 99) < STALL_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < STALL_PCT)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			send_beat(CMD_DATA, w[8*i +: 8]);
	endtask

	// drop valid and wait until every predicted beat has come out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input cfg_idx_t idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] mn, input logic [63:0] mx,
			input logic [63:0] tl, input logic [63:0] tg);
		cfg_beat(CFG_MIN_LENGTH, mn);
		cfg_beat(CFG_MAX_LENGTH, mx);
		cfg_beat(CFG_TAG_LENGTH, tl);
		cfg_beat(CFG_TAG_BYTES, tg);
		cfg_valid   <= 1'b0;
		cur_min     = mn[LEN_W-1:0];
		cur_max     = mx[LEN_W-1:0];
		cur_tag_len = tl[TAG_LEN_W-1:0];
		cur_tag     = tg;
	endtask

	// ignored bytes while halted, then resync
	task automatic recover();
		int n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			send_beat(CMD_DATA, rand_byte());
		send_beat(CMD_RESYNC, rand_byte());
	endtask

	task automatic send_bad_length(input logic [31:0] len);
		send_word(len);
		recover();
	endtask

	task automatic send_frame(input int pay_n, input bit bad_sum, input bit bad_tag,
			input int fill);
		logic [7:0]  body[$];
		logic [31:0] sum;
		int unsigned lo;
		int unsigned hi;
		int          tl;
		int          pick;
		tl = eff_tag_len();
		for (int i = 0; i < tl; i++)
			body.push_back(cur_tag[8*i +: 8]);
		if (bad_tag && tl > 0) begin
			pick = $urandom_range(0, tl - 1);
			body[pick] = body[pick] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < pay_n; i++)
			body.push_back((fill < 0) ? rand_byte() : 8'(fill));
		lo = 1;
		hi = 0;
		foreach (body[i]) begin
			lo = (lo + body[i]) % ADLER_MOD;
			hi = (hi + lo) % ADLER_MOD;
		end
		sum = {hi[15:0], lo[15:0]};
		if (bad_sum)
			sum = sum ^ (32'd1 << $urandom_range(0, 31));
		send_word(body.size() + CHECK_BYTES);
		foreach (body[i])
			send_beat(CMD_DATA, body[i]);
		send_word(sum);
	endtask

	task automatic random_frame(input bit bad_sum, input bit bad_tag);
		int          tl;
		int unsigned lo_len;
		int unsigned hi_len;
		tl = eff_tag_len();
		lo_len = (cur_min > tl + CHECK_BYTES) ? cur_min : tl + CHECK_BYTES;
		hi_len = (cur_max < tl + CHECK_BYTES + PAYLOAD_MAX) ?
			cur_max : tl + CHECK_BYTES + PAYLOAD_MAX;
		if (lo_len <= hi_len) begin
			send_frame($urandom_range(lo_len, hi_len) - tl - CHECK_BYTES,
				bad_sum, bad_tag, -1);
			if (bad_sum || (bad_tag && tl > 0))
				recover();
			else if ($urandom_range(0, 9) == 0)
				send_beat(CMD_RESYNC, rand_byte());
		end else begin
			send_frame($urandom_range(0, 4), bad_sum, bad_tag, -1);
			recover();
		end
	endtask

	task automatic random_bad_length();
		int          tl;
		logic [31:0] len;
		tl = eff_tag_len();
		case ($urandom_range(0, 3))
			0: len = (cur_min > 0) ? $urandom_range(0, cur_min - 1) : 32'd0;
			1: len = $urandom_range(0, tl + CHECK_BYTES - 1);
			2: len = cur_max + $urandom_range(1, 3);
			default: len = $urandom | 32'h0800_0000;
		endcase
		send_bad_length(len);
	endtask

	// length header, part of the body, then resync
	task automatic cut_frame();
		int          tl;
		int unsigned len;
		int          n;
		tl  = eff_tag_len();
		len = tl + CHECK_BYTES + $urandom_range(0, PAYLOAD_MAX);
		if (len < cur_min)
			len = cur_min;
		send_word(len);
		n = $urandom_range(0, (len > 40) ? 40 : len - 1);
		for (int i = 0; i < n; i++)
			send_beat(CMD_DATA, rand_byte());
		send_beat(CMD_RESYNC, rand_byte());
	endtask

	task automatic noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_beat(($urandom_range(0, 3) == 0) ? CMD_RESYNC : CMD_DATA, rand_byte());
		send_beat(CMD_RESYNC, rand_byte());
	endtask

	task automatic random_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			random_frame(1'b0, 1'b0);
		else if (r < 70)
			random_frame(1'b1, $urandom_range(0, 3) == 0);
		else if (r < 78)
			random_frame(1'b0, 1'b1);
		else if (r < 85)
			random_bad_length();
		else if (r < 93)
			cut_frame();
		else
			noise();
	endtask

	task automatic random_settings();
		logic [63:0] mn;
		logic [63:0] mx;
		logic [63:0] tl;
		mn = {32'($urandom), 32'($urandom_range(0, 14))};
		case ($urandom_range(0, 3))
			0: mx = LEN_TOP;
			1: mx = {32'($urandom), 32'($urandom)};
			default: mx = {32'($urandom), 32'($urandom_range(8, 48))};
		endcase
		tl = {32'($urandom), 28'($urandom), 4'($urandom_range(0, 15))};
		configure(mn, mx, tl, {32'($urandom), 32'($urandom)});
	endtask

	initial begin
		int phase_end;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_MIN_LENGTH;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_DATA;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values
		configure(64'd4, LEN_TOP, 64'd0, 64'd0);
		send_frame(0, 1'b0, 1'b0, -1);
		send_frame(2, 1'b0, 1'b0, 8'h00);
		send_frame(30, 1'b0, 1'b0, 8'hFF);
		send_bad_length(32'd3);
		send_bad_length(32'hFFFF_FFFF);
		send_bad_length(32'd67108865);
		send_frame(3, 1'b1, 1'b0, -1);
		recover();
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_RESYNC, 8'hFF);

		// oversized tag length, all-ones tag
		settle();
		configure(64'd0, LEN_TOP, 64'd15, '1);
		send_beat(CMD_RESYNC, 8'h00);
		send_bad_length(32'd11);
		send_frame(0, 1'b0, 1'b0, -1);
		send_frame(3, 1'b0, 1'b1, -1);
		recover();
		send_frame(3, 1'b1, 1'b1, -1);
		recover();

		// min and max both at the reset maximum length
		settle();
		configure(LEN_TOP, LEN_TOP, 64'd8, {32'($urandom), 32'($urandom)});
		send_beat(CMD_RESYNC, 8'h00);
		send_word(32'd67108864);
		send_beat(CMD_DATA, rand_byte());
		send_beat(CMD_DATA, rand_byte());
		send_beat(CMD_RESYNC, rand_byte());
		send_bad_length(32'd67108863);
		send_bad_length(32'd0);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			stall_on = (ph != 2);
			if (ph == 0)
				configure(64'd0, LEN_TOP, 64'($urandom_range(0, 15)),
					{32'($urandom), 32'($urandom)});
			else
				random_settings();
			send_beat(CMD_RESYNC, rand_byte());
			// long frame wraps the low Adler sum
			if (ph == 0)
				send_frame(260, 1'b0, 1'b0, 8'hFF);
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end)
				random_step();
		end
		settle();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/lpaf_pkg.sv
hdl/length_prefixed_adler_frame_checker.sv
hdl/lpaf_checker.sv
sim/lpaf_tb_pkg.sv
sim/lpaf_frame_monitor.sv
sim/tb_length_prefixed_adler_frame_checker.sv
